/* design/ldf_pkg.sv */
// shared types, constants and helpers of the length-prefixed deframer
package ldf_pkg;

  localparam int unsigned LENGTH_BITS = 32;
  localparam int unsigned LEN_FIELD_W = 32;

  localparam int unsigned HDR_IDX_W = 4;
  localparam logic [HDR_IDX_W-1:0] HDR_MAGIC_END  = 4'd4;
  localparam logic [HDR_IDX_W-1:0] HDR_FIELDS_END = 4'd8;
  localparam logic [HDR_IDX_W-1:0] HDR_CTRL_END   = 4'd12;
  localparam logic [HDR_IDX_W-1:0] HDR_VERSION_POS = 4'd4;
  localparam logic [HDR_IDX_W-1:0] HDR_FLAGS_POS   = 4'd5;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_POS    = 4'd15;

  localparam logic [7:0] HDR_VERSION   = 8'h01;
  localparam logic [7:0] FLAG_BODY     = 8'h01;

  localparam logic [LEN_FIELD_W-1:0] MAX_CONTROL_RESET = 32'd1048576;
  localparam logic [LEN_FIELD_W-1:0] MAX_BODY_RESET    = 32'd16777216;

  localparam int unsigned CFG_DATA_W = 32;
  localparam logic CFG_MAX_CONTROL = 1'b0;
  localparam logic CFG_MAX_BODY    = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_CONTROL = 4'b0010,
    PH_BODY    = 4'b0100,
    PH_HALTED  = 4'b1000
  } ldf_phase_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MAGIC    = 3'd1,
    ERR_HEADER   = 3'd2,
    ERR_CTRL_LEN = 3'd3,
    ERR_BODY_LEN = 3'd4
  } ldf_err_e;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       section;
    logic       frame_last;
    logic       has_body;
    ldf_err_e   error_code;
    logic       halted;
    logic       at_boundary;
  } ldf_result_t;

  typedef struct packed {
    logic halted;
    logic at_boundary;
  } ldf_parse_status_t;

  typedef struct packed {
    logic                   full;
    logic [QUEUE_CNT_W-1:0] count;
  } ldf_queue_status_t;

  function automatic logic [7:0] ldf_magic(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = 8'h4C;
      2'd1:    b = 8'h4F;
      2'd2:    b = 8'h4F;
      default: b = 8'h50;
    endcase
    return b;
  endfunction

  function automatic logic ldf_fits(input logic [LEN_FIELD_W-1:0] v);
    return (v >> LENGTH_BITS) == '0;
  endfunction

endpackage

/* design/ldf_parser.sv */
// front end: header parse, length checks and per-byte classification
module ldf_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [7:0]                      byte_i,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [ldf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            push_o,
  output ldf_pkg::ldf_result_t            result_o,
  output ldf_pkg::ldf_parse_status_t      status_o
);

  ldf_pkg::ldf_phase_e phase_q, phase_d;
  logic [ldf_pkg::HDR_IDX_W-1:0] idx_q, idx_d;
  ldf_pkg::ldf_err_e err_q, err_d;
  ldf_pkg::ldf_err_e byte_err;
  logic flags_q, flags_d;
  logic [ldf_pkg::LEN_FIELD_W-1:0] ctrl_q, ctrl_d, body_q, body_d;
  logic [ldf_pkg::LEN_FIELD_W-1:0] max_ctrl_q, max_body_q;
  logic last;
  ldf_pkg::ldf_result_t res;

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    err_d    = err_q;
    flags_d  = flags_q;
    ctrl_d   = ctrl_q;
    body_d   = body_q;
    byte_err = ldf_pkg::ERR_NONE;
    last     = 1'b0;
    res      = '0;
    res.has_body = flags_q;
    if (accept_i) begin
      case (phase_q)
        ldf_pkg::PH_HEADER: begin
          if (idx_q < ldf_pkg::HDR_MAGIC_END) begin
            if (byte_i != ldf_pkg::ldf_magic(idx_q[1:0])) byte_err = ldf_pkg::ERR_MAGIC;
          end else if (idx_q < ldf_pkg::HDR_FIELDS_END) begin
            if (idx_q == ldf_pkg::HDR_VERSION_POS) begin
              if (byte_i != ldf_pkg::HDR_VERSION) byte_err = ldf_pkg::ERR_HEADER;
            end else if (idx_q == ldf_pkg::HDR_FLAGS_POS) begin
              flags_d = |(byte_i & ldf_pkg::FLAG_BODY);
              if ((byte_i & ~ldf_pkg::FLAG_BODY) != 8'h00) byte_err = ldf_pkg::ERR_HEADER;
            end else if (byte_i != 8'h00) begin
              byte_err = ldf_pkg::ERR_HEADER;
            end
          end else if (idx_q < ldf_pkg::HDR_CTRL_END) begin
            ctrl_d = {ctrl_q[ldf_pkg::LEN_FIELD_W-9:0], byte_i};
          end else begin
            body_d = {body_q[ldf_pkg::LEN_FIELD_W-9:0], byte_i};
          end
          if (err_q == ldf_pkg::ERR_NONE && byte_err != ldf_pkg::ERR_NONE) err_d = byte_err;
          if (idx_q == ldf_pkg::HDR_LAST_POS) begin
            idx_d = '0;
            if (err_d == ldf_pkg::ERR_NONE) begin
              if (ctrl_d == '0 || ctrl_d > max_ctrl_q || !ldf_pkg::ldf_fits(ctrl_d)) begin
                err_d = ldf_pkg::ERR_CTRL_LEN;
              end else if (body_d > max_body_q || !ldf_pkg::ldf_fits(body_d)
                           || (!flags_d && body_d != '0)) begin
                err_d = ldf_pkg::ERR_BODY_LEN;
              end
            end
            phase_d = (err_d != ldf_pkg::ERR_NONE) ? ldf_pkg::PH_HALTED : ldf_pkg::PH_CONTROL;
          end else begin
            idx_d = idx_q + 1'b1;
          end
          res.has_body = flags_d;
        end
        ldf_pkg::PH_CONTROL: begin
          res.payload_valid = 1'b1;
          res.payload_byte  = byte_i;
          ctrl_d = ctrl_q - 1'b1;
          if (ctrl_d == '0) begin
            if (body_q == '0) last = 1'b1;
            else phase_d = ldf_pkg::PH_BODY;
          end
        end
        ldf_pkg::PH_BODY: begin
          res.payload_valid = 1'b1;
          res.payload_byte  = byte_i;
          res.section       = 1'b1;
          body_d = body_q - 1'b1;
          if (body_d == '0) last = 1'b1;
        end
        default: begin
        end
      endcase
      if (last) begin
        phase_d = ldf_pkg::PH_HEADER;
        idx_d   = '0;
        flags_d = 1'b0;
        ctrl_d  = '0;
        body_d  = '0;
      end
    end
    res.frame_last  = last;
    res.halted      = (phase_d == ldf_pkg::PH_HALTED);
    res.error_code  = res.halted ? err_d : ldf_pkg::ERR_NONE;
    res.at_boundary = (phase_d == ldf_pkg::PH_HEADER) && (idx_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ldf_pkg::PH_HEADER;
      idx_q      <= '0;
      err_q      <= ldf_pkg::ERR_NONE;
      flags_q    <= 1'b0;
      ctrl_q     <= '0;
      body_q     <= '0;
      max_ctrl_q <= ldf_pkg::MAX_CONTROL_RESET;
      max_body_q <= ldf_pkg::MAX_BODY_RESET;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      err_q   <= err_d;
      flags_q <= flags_d;
      ctrl_q  <= ctrl_d;
      body_q  <= body_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          ldf_pkg::CFG_MAX_CONTROL: max_ctrl_q <= cfg_data_i;
          ldf_pkg::CFG_MAX_BODY:    max_body_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  assign push_o   = accept_i;
  assign result_o = res;
  assign status_o.halted      = (phase_q == ldf_pkg::PH_HALTED);
  assign status_o.at_boundary = (phase_q == ldf_pkg::PH_HEADER) && (idx_q == '0);

endmodule

/* design/ldf_queue.sv */
// result queue between the parser and the output channel
module ldf_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  ldf_pkg::ldf_result_t        push_data_i,
  input  logic                        pop_i,
  output logic                        valid_o,
  output ldf_pkg::ldf_result_t        data_o,
  output ldf_pkg::ldf_queue_status_t  status_o
);

  ldf_pkg::ldf_result_t entry_q [ldf_pkg::QUEUE_DEPTH];
  logic [ldf_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ldf_pkg::QUEUE_CNT_W-1:0] count_q, count_d;
  logic do_push, do_pop;

  localparam logic [ldf_pkg::QUEUE_PTR_W-1:0] LastPtr =
    ldf_pkg::QUEUE_PTR_W'(ldf_pkg::QUEUE_DEPTH - 1);
  localparam logic [ldf_pkg::QUEUE_CNT_W-1:0] FullCount =
    ldf_pkg::QUEUE_CNT_W'(ldf_pkg::QUEUE_DEPTH);

  assign do_pop  = pop_i && (count_q != '0);
  assign do_push = push_i && (count_q != FullCount);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_data_i;
  end

  assign valid_o         = (count_q != '0);
  assign data_o          = entry_q[rd_ptr_q];
  assign status_o.count  = count_q;
  assign status_o.full   = (count_q == FullCount);

endmodule

/* design/length_prefixed_deframer.sv */
// top level of the length-prefixed stream deframer
//
// s_axis carries one raw stream byte per item; m_axis returns exactly one
// result item for every accepted byte, in order. payload bytes of the
// control section, then of the body section, are passed on as they arrive,
// marked in tuser; tlast marks the final payload byte of a frame. header
// bytes and bytes seen while halted give items with no payload.
// a result is registered in the result queue before it is offered on m_axis.
// throughput: one byte per cycle while the queue is not full, set by the
// header and length-counter update in the parser, done as each byte is accepted.
// a two-item result queue sits between parser and m_axis; while m_axis is
// stalled the queue fills and s_axis_tready drops once it is full.
// reset clears the parser to the start of a header, empties the queue and
// loads the default length limits. a failed header check is sticky: every
// following item reports halted and the error code until the next reset.
// the user must write limits through the cfg port only while no item is in flight; the block does not enforce it.
module length_prefixed_deframer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // in_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // payload_byte[7:0], has_body[8], error_code[11:9], halted[12], at_boundary[13], zero
  output logic [15:0]                    m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,  // payload_valid[0], section[1]
  output logic                           m_axis_tlast,  // frame_last
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [ldf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic push, accept;
  ldf_pkg::ldf_result_t push_data, out_data;
  ldf_pkg::ldf_parse_status_t parse_status;
  ldf_pkg::ldf_queue_status_t queue_status;

  assign s_axis_tready = !queue_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ldf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .result_o    (push_data),
    .status_o    (parse_status)
  );

  ldf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_data),
    .status_o    (queue_status)
  );

  assign m_axis_tdata = {2'b00, out_data.at_boundary, out_data.halted, out_data.error_code,
                         out_data.has_body, out_data.payload_byte};
  assign m_axis_tuser = {out_data.section, out_data.payload_valid};
  assign m_axis_tlast = out_data.frame_last;

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse_status.halted |=> parse_status.halted)
    else $error("parser left halted state");

  // the queue never drops an accepted item
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !queue_status.full)
    else $error("result pushed into full queue");

  // a payload item never carries an error
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (!m_axis_tdata[12] && m_axis_tdata[11:9] == ldf_pkg::ERR_NONE))
    else $error("payload item flagged with error");

  // a halted parser only produces halted items
  a_halted_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && parse_status.halted) |-> (push_data.halted && !push_data.payload_valid))
    else $error("item accepted while halted was not reported halted");

endmodule
